// ----- hw/rtl/gfe_pkg.sv -----
// Griewank fitness evaluator: shared types, constants and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps

package gfe_pkg;

   localparam int COORD_W   = 32;
   localparam int FIT_W     = 64;
   localparam int PROD_W    = 32;
   localparam int CORDIC_W  = 34;
   localparam int STEP_W    = 7;
   localparam int CORDIC_STEPS = 24;

   localparam logic [STEP_W-1:0] RECIP_STEPS = 7'd32;

   localparam logic signed [PROD_W-1:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565276;
   localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [5:0] FIT_DIVISOR = 6'd40;
   localparam logic [5:0] FIT_HALF    = 6'd20;
   localparam int         FIT_DIGIT_W = 16;
   localparam int         FIT_RECIP_SHIFT = 27;
   localparam logic [21:0] FIT_RECIP  = 22'd3355444;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord;
      logic                      last;
   } req_word_type;

   typedef struct packed {
      logic [FIT_W-1:0] fitness;
      logic             saturated;
   } rsp_word_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORDIC_W-1:0] v;
      unique case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/gfe_stream_if.sv -----
// Valid/ready stream interface carrying one word per handshake.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps

interface gfe_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// ----- hw/rtl/gfe_serial_div.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit dividend, narrow divisor.
// Depends on gfe_pkg.
`timescale 1ns / 1ps

module gfe_serial_div #(
   parameter int DIVISOR_W = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gfe_pkg::div_cmd_type   cmd,
   input  logic [63:0]            dividend,
   input  logic [DIVISOR_W-1:0]   divisor,
   output gfe_pkg::div_status_type status,
   output logic [63:0]            quotient
);
   import gfe_pkg::*;

   logic [63:0]          q_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] d_ff;
   logic [STEP_W-1:0]    cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIVISOR_W:0]   trial_in;
   logic                 fits_in;

   assign trial_in = {rem_ff, q_ff[63]};
   assign fits_in  = trial_in >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
            rem_ff  <= '0;
            d_ff    <= divisor;
            q_ff    <= dividend;
         end else if (busy_ff) begin
            q_ff <= {q_ff[62:0], fits_in};
            if (fits_in) begin
               rem_ff <= DIVISOR_W'(trial_in - {1'b0, d_ff});
            end else begin
               rem_ff <= trial_in[DIVISOR_W-1:0];
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

// ----- hw/rtl/griewank_fitness_eval.sv -----
// Griewank fitness evaluator top level: sequencer, shared multiplier, CORDIC.
// Depends on gfe_pkg, gfe_stream_if and gfe_serial_div.
`timescale 1ns / 1ps
//
// Usage: req_port takes one coordinate word (signed Q12.20 coord, last flag) per
// handshake. After the word marked last, rsp_port offers one word: fitness
// (unsigned Q34.30, saturating) and saturated. Words not marked last give nothing.
// Each coordinate runs, between its handshake and the next possible one, a serial
// divide for 1/(j+1) started beside the squaring, six passes through the one
// 33x33 multiplier and 24 CORDIC iterations on a single shift-add stage. After
// the last coordinate, the divide by 40 runs as four 16-bit digit steps through
// the same multiplier, then the result register is loaded for rsp_port.
// A coordinate past MAX_DIM skips the evaluation steps and only marks overflow;
// marked last, it goes straight to the divide by 40. req_ready is high only while the
// sequencer is idle.
// The result sits in an output register; a stalled receiver does not block the
// next vector's coordinates, only the moment the next result must be loaded.
// Reset (synchronous, active high) clears the sum, index and overflow flag,
// sets the product to one and drops any pending result.
//
module griewank_fitness_eval #(
   parameter int MAX_DIM = 1024
) (
   input  logic         clock,
   input  logic         reset,
   gfe_stream_if.sink   req_port,
   gfe_stream_if.source rsp_port
);
   import gfe_pkg::*;

   localparam int IDX_W = $clog2(MAX_DIM + 1);
   localparam int DIV_W = (IDX_W > 6) ? IDX_W : 6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_SQACC, ST_DIVW, ST_ANG, ST_ALO, ST_AHI, ST_PH,
      ST_ZI, ST_CORD, ST_CLAMP, ST_PROD, ST_FIN, ST_DMUL, ST_DSUB, ST_OUT
   } state_type;

   state_type                  state_ff;
   logic [FIT_W-1:0]           sum_ff;
   logic signed [PROD_W-1:0]   cprod_ff;
   logic [IDX_W-1:0]           index_ff;
   logic                       ov_ff;
   logic [31:0]                m_ff;
   logic                       last_ff;
   logic [31:0]                r_ff;
   logic [11:0]                ahi_ff;
   logic [31:0]                plo_ff;
   logic                       flip_ff;
   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic [4:0]                 iter_ff;
   logic                       sat_ff;
   logic [63:0]                prod_ff;
   logic                       rsp_valid_ff;
   rsp_word_type               rsp_ff;
   logic [63:0]                num_ff;
   logic [63:0]                quo_ff;
   logic [5:0]                 drem_ff;
   logic [1:0]                 dcnt_ff;

   logic signed [32:0]         mul_a_in, mul_b_in;
   logic [IDX_W-1:0]           n_in;
   logic [31:0]                coord_u_in;
   logic [31:0]                m_in;
   logic [64:0]                sq_sum_in;
   logic [63:0]                sq_in;
   logic [31:0]                p_in, pf_in, mag_in;
   logic                       flip_in;
   logic signed [CORDIC_W-1:0] xc_in;
   logic signed [PROD_W-1:0]   c_in;
   logic [63:0]                bias_in;
   logic [64:0]                num_sum_in;
   logic [63:0]                num_in;
   logic signed [63:0]         round_in;
   logic [21:0]                dv_in;
   logic [FIT_DIGIT_W-1:0]     dq_in;
   logic [21:0]                dr_in;
   logic                       rsp_load_in;

   div_cmd_type                div_cmd_in;
   div_status_type             div_status;
   logic [63:0]                div_dividend_in;
   logic [DIV_W-1:0]           div_divisor_in;
   logic [63:0]                div_q;

   gfe_serial_div #(.DIVISOR_W(DIV_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd_in),
      .dividend  (div_dividend_in),
      .divisor   (div_divisor_in),
      .status    (div_status),
      .quotient  (div_q)
   );

   function automatic logic signed [PROD_W-1:0] flip_in_c(
      input logic f, input logic signed [CORDIC_W-1:0] x);
      logic signed [CORDIC_W-1:0] v;
      v = f ? -x : x;
      return v[PROD_W-1:0];
   endfunction

   assign n_in       = index_ff + 1'b1;
   assign coord_u_in = req_port.payload.coord;
   assign m_in       = coord_u_in[31] ? (32'd0 - coord_u_in) : coord_u_in;
   assign sq_in      = (prod_ff + 64'd512) >> 10;
   assign sq_sum_in  = {1'b0, sum_ff} + {1'b0, sq_in};
   assign p_in       = plo_ff + prod_ff[31:0];
   assign flip_in    = p_in[31] ^ p_in[30];
   assign pf_in      = flip_in ? (p_in + 32'h8000_0000) : p_in;
   assign mag_in     = pf_in[31] ? (32'd0 - pf_in) : pf_in;
   assign round_in   = $signed(prod_ff) + 64'sd536870912;

   always_comb begin
      if (x_ff > 34'sd1073741824) begin
         xc_in = 34'sd1073741824;
      end else if (x_ff < -34'sd1073741824) begin
         xc_in = -34'sd1073741824;
      end else begin
         xc_in = x_ff;
      end
   end
   assign c_in = flip_in_c(flip_ff, xc_in);

   assign bias_in    = 64'(ONE_Q30) - 64'($signed(cprod_ff));
   assign num_sum_in = {1'b0, sum_ff} + {1'b0, bias_in};
   assign num_in     = num_sum_in[64] ? '1 : num_sum_in[63:0];

   assign dv_in = {drem_ff, num_ff[63:64-FIT_DIGIT_W]};
   assign dq_in = prod_ff[FIT_RECIP_SHIFT+FIT_DIGIT_W-1:FIT_RECIP_SHIFT];
   assign dr_in = dv_in - (22'(dq_in) * 22'(FIT_DIVISOR));

   assign rsp_load_in = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      mul_a_in = '0;
      mul_b_in = '0;
      unique case (state_ff)
         ST_SQ: begin
            mul_a_in = {1'b0, m_ff};
            mul_b_in = {1'b0, m_ff};
         end
         ST_ANG: begin
            mul_a_in = {1'b0, m_ff};
            mul_b_in = {1'b0, r_ff};
         end
         ST_ALO: begin
            mul_a_in = {1'b0, prod_ff[50:19]};
            mul_b_in = {1'b0, INV_TWO_PI_Q32};
         end
         ST_AHI: begin
            mul_a_in = {21'd0, ahi_ff};
            mul_b_in = {1'b0, INV_TWO_PI_Q32};
         end
         ST_PH: begin
            mul_a_in = {1'b0, mag_in};
            mul_b_in = {1'b0, TWO_PI_Q29};
         end
         ST_CLAMP: begin
            mul_a_in = {cprod_ff[31], cprod_ff};
            mul_b_in = {c_in[31], c_in};
         end
         ST_DMUL: begin
            mul_a_in = {11'd0, dv_in};
            mul_b_in = {11'd0, FIT_RECIP};
         end
         default: begin
            mul_a_in = '0;
            mul_b_in = '0;
         end
      endcase
   end

   always_comb begin
      div_cmd_in.start = (state_ff == ST_SQ);
      div_cmd_in.steps = RECIP_STEPS;
      div_dividend_in  = {32'h8000_0000 + 32'(n_in >> 1), 32'd0};
      div_divisor_in   = DIV_W'(n_in);
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a_in * mul_b_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         cprod_ff     <= ONE_Q30;
         index_ff     <= '0;
         ov_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         if (rsp_load_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_port.valid) begin
                  m_ff    <= m_in;
                  last_ff <= req_port.payload.last;
                  if (index_ff >= IDX_W'(MAX_DIM)) begin
                     ov_ff <= 1'b1;
                     if (req_port.payload.last) begin
                        state_ff <= ST_FIN;
                     end
                  end else begin
                     state_ff <= ST_SQ;
                  end
               end
            end
            ST_SQ: state_ff <= ST_SQACC;
            ST_SQACC: begin
               if (sq_sum_in[64]) begin
                  sum_ff <= '1;
                  ov_ff  <= 1'b1;
               end else begin
                  sum_ff <= sq_sum_in[63:0];
               end
               state_ff <= ST_DIVW;
            end
            ST_DIVW: begin
               if (div_status.done) begin
                  r_ff     <= div_q[31:0];
                  state_ff <= ST_ANG;
               end
            end
            ST_ANG: state_ff <= ST_ALO;
            ST_ALO: begin
               ahi_ff   <= prod_ff[62:51];
               state_ff <= ST_AHI;
            end
            ST_AHI: begin
               plo_ff   <= prod_ff[63:32];
               state_ff <= ST_PH;
            end
            ST_PH: begin
               flip_ff  <= flip_in;
               state_ff <= ST_ZI;
            end
            ST_ZI: begin
               z_ff     <= $signed({3'b000, prod_ff[61:31]});
               x_ff     <= CORDIC_GAIN_Q30;
               y_ff     <= '0;
               iter_ff  <= '0;
               state_ff <= ST_CORD;
            end
            ST_CORD: begin
               if (!z_ff[CORDIC_W-1]) begin
                  x_ff <= x_ff - (y_ff >>> iter_ff);
                  y_ff <= y_ff + (x_ff >>> iter_ff);
                  z_ff <= z_ff - atan_q30(iter_ff);
               end else begin
                  x_ff <= x_ff + (y_ff >>> iter_ff);
                  y_ff <= y_ff - (x_ff >>> iter_ff);
                  z_ff <= z_ff + atan_q30(iter_ff);
               end
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_CLAMP;
               end
            end
            ST_CLAMP: state_ff <= ST_PROD;
            ST_PROD: begin
               cprod_ff <= PROD_W'(round_in >>> 30);
               index_ff <= index_ff + 1'b1;
               state_ff <= last_ff ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
               sat_ff   <= ov_ff | num_sum_in[64];
               num_ff   <= num_in;
               quo_ff   <= '0;
               drem_ff  <= '0;
               dcnt_ff  <= '0;
               state_ff <= ST_DMUL;
            end
            ST_DMUL: state_ff <= ST_DSUB;
            ST_DSUB: begin
               quo_ff  <= {quo_ff[63-FIT_DIGIT_W:0], dq_in};
               drem_ff <= dr_in[5:0];
               num_ff  <= {num_ff[63-FIT_DIGIT_W:0], {FIT_DIGIT_W{1'b0}}};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == 2'd3) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DMUL;
               end
            end
            ST_OUT: begin
               if (rsp_load_in) begin
                  rsp_ff.fitness    <= quo_ff + 64'(drem_ff >= FIT_HALF);
                  rsp_ff.saturated  <= sat_ff;
                  sum_ff            <= '0;
                  cprod_ff          <= ONE_Q30;
                  index_ff          <= '0;
                  ov_ff             <= 1'b0;
                  state_ff          <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_port.ready   = (state_ff == ST_IDLE);
   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_ff;

endmodule

// ----- hw/rtl/gfe_checker.sv -----
// Port-level checks for the Griewank fitness evaluator, bound to the top level.
// Depends on gfe_pkg and griewank_fitness_eval.
`timescale 1ns / 1ps

module gfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_fitness,
   input logic        rsp_saturated
);
   import gfe_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fitness) && $stable(rsp_saturated))
      else $error("result word changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word pending after reset");

   a_fit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_fitness <= 64'h0666_6666_6666_6666)
      else $error("fitness above full-scale sum divided by 40");

endmodule

bind griewank_fitness_eval gfe_checker u_gfe_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_port.valid),
   .rsp_ready     (rsp_port.ready),
   .rsp_fitness   (rsp_port.payload.fitness),
   .rsp_saturated (rsp_port.payload.saturated)
);
